@@ rtl/core/cht_pkg.sv @@
package cht_pkg;

   localparam int MaxBuckets  = 16;
   localparam int PoolEntries = 64;
   localparam int IdxW        = 6;
   localparam int LinkW       = 7;
   localparam int BktW        = 4;
   localparam logic [31:0] MurmurM = 32'h5bd1e995;
   localparam logic [LinkW-1:0] NullLink = LinkW'(PoolEntries);

   typedef enum logic [2:0] {
      KIND_INSERT = 3'd0,
      KIND_LOOKUP = 3'd1,
      KIND_REMOVE = 3'd2,
      KIND_CLEAR  = 3'd3,
      KIND_MAXKEY = 3'd4
   } kind_type;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NOTFOUND = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_EMPTY    = 2'd3;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] key;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] found_value;
      logic [31:0] max_key;
      logic [6:0]  removed_count;
      logic [6:0]  entry_count;
   } rsp_type;

   typedef struct packed {
      logic        start;
      logic [31:0] key;
      logic [4:0]  nbuckets;
   } hash_cmd_type;

   typedef struct packed {
      logic            done;
      logic [BktW-1:0] bucket;
   } hash_res_type;

endpackage

@@ rtl/core/chained_hash_table_engine.sv @@
// channel | dir | handshake      | word
// req_    | in  | valid / stall  | req_type (kind, key, value)
// rsp_    | out | valid / stall  | rsp_type
// csr_    | in  | valid / ready  | bucket_count, 5 bits
// insert/lookup/remove: the hash with its modulo steps, a head step, then a read and a
// check per chain link on the entry memory read port, then an output step; max key
// sweeps all 64 entries with a read and a check each; clear resets heads and used bits
// at once and waits for the hash; insert also searches the used bits combinationally.
// reset is synchronous; stored data need no clear, the used bits and heads reset.
// a held result in rsp_ stalls the block; req_stall is high while busy.
module chained_hash_table_engine
   import cht_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_word,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_word,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [4:0] csr_data
);

   typedef enum logic [3:0] {
      S_IDLE, S_HASH, S_HEAD, S_RD, S_CHK, S_SWEEP, S_SWCHK, S_OUT
   } state_type;

   state_type        state_ff;
   req_type          req_ff;
   logic [4:0]       bcount_ff;
   logic [LinkW-1:0] heads_ff [MaxBuckets];
   logic [PoolEntries-1:0] used_ff;
   logic [6:0]       count_ff;
   logic [LinkW-1:0] cur_ff, prev_ff;
   logic [6:0]       steps_ff;
   logic [BktW-1:0]  bkt_ff;
   logic [IdxW-1:0]  slot_ff;
   logic             any_ff;
   rsp_type          rsp_ff;
   logic             rsp_valid_ff;

   logic [31:0]      mkey [PoolEntries];
   logic [31:0]      mval [PoolEntries];
   logic [LinkW-1:0] mnext [PoolEntries];
   logic [31:0]      rd_key_ff, rd_val_ff;
   logic [LinkW-1:0] rd_next_ff;

   hash_cmd_type hcmd;
   hash_res_type hres;

   logic             rd_en, wr_en, wr_full;
   logic [IdxW-1:0]  rd_addr, wr_addr;
   logic [LinkW-1:0] wr_next;
   logic [IdxW-1:0]  free_idx;
   logic             free_ok;

   cht_hash u_hash (.clock(clock), .reset(reset), .cmd(hcmd), .res(hres));

   assign hcmd.start    = (state_ff == S_IDLE) && req_valid && !rsp_valid_ff;
   assign hcmd.key      = req_word.key;
   assign hcmd.nbuckets = bcount_ff;

   always_comb begin
      free_idx = '0;
      free_ok  = 1'b0;
      for (int i = PoolEntries - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_idx = IdxW'(i);
            free_ok  = 1'b1;
         end
      end
   end

   assign req_stall = !((state_ff == S_IDLE) && !rsp_valid_ff);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_key_ff  <= mkey[rd_addr];
         rd_val_ff  <= mval[rd_addr];
         rd_next_ff <= mnext[rd_addr];
      end
      if (wr_en) begin
         mnext[wr_addr] <= wr_next;
         if (wr_full) begin
            mkey[wr_addr] <= req_ff.key;
            mval[wr_addr] <= req_ff.value;
         end
      end
   end

   // memory port control
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = cur_ff[IdxW-1:0];
      wr_en   = 1'b0;
      wr_full = 1'b0;
      wr_addr = slot_ff;
      wr_next = NullLink;
      unique case (state_ff)
         S_RD:    rd_en = 1'b1;
         S_SWEEP: begin
            rd_en   = 1'b1;
            rd_addr = steps_ff[IdxW-1:0];
         end
         S_HEAD: begin
            if (req_ff.kind == KIND_INSERT) begin
               wr_en   = 1'b1;
               wr_full = 1'b1;
            end
         end
         S_CHK: begin
            if (req_ff.kind == KIND_INSERT && rd_next_ff[LinkW-1]) begin
               wr_en   = 1'b1;
               wr_addr = cur_ff[IdxW-1:0];
               wr_next = {1'b0, slot_ff};
            end else if (req_ff.kind == KIND_REMOVE && rd_key_ff == req_ff.key
                         && !prev_ff[LinkW-1]) begin
               wr_en   = 1'b1;
               wr_addr = prev_ff[IdxW-1:0];
               wr_next = rd_next_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         bcount_ff    <= 5'd10;
         used_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MaxBuckets; i++) heads_ff[i] <= NullLink;
      end else begin
         if (csr_valid) bcount_ff <= csr_data;
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid && !rsp_valid_ff) begin
                  req_ff   <= req_word;
                  rsp_ff   <= '0;
                  steps_ff <= '0;
                  any_ff   <= 1'b0;
                  prev_ff  <= NullLink;
                  if (req_word.kind == KIND_CLEAR) begin
                     used_ff  <= '0;
                     count_ff <= '0;
                     for (int i = 0; i < MaxBuckets; i++) heads_ff[i] <= NullLink;
                     state_ff <= S_HASH;
                  end else if (req_word.kind == KIND_MAXKEY) begin
                     state_ff <= S_SWEEP;
                  end else if (req_word.kind == KIND_INSERT && !free_ok) begin
                     state_ff <= S_HASH;
                  end else begin
                     slot_ff  <= free_idx;
                     state_ff <= S_HASH;
                  end
               end
            end
            S_HASH: begin
               // unused kinds, clear and pool full also wait here for the hash to drain
               if (hres.done) begin
                  bkt_ff <= hres.bucket;
                  if (req_ff.kind == KIND_INSERT && !free_ok) rsp_ff.status <= ST_FULL;
                  if (req_ff.kind == KIND_CLEAR || (req_ff.kind == KIND_INSERT && !free_ok)
                      || (req_ff.kind != KIND_INSERT && req_ff.kind != KIND_LOOKUP
                          && req_ff.kind != KIND_REMOVE)) begin
                     state_ff <= S_OUT;
                  end else begin
                     state_ff <= S_HEAD;
                  end
               end
            end
            S_HEAD: begin
               cur_ff <= heads_ff[bkt_ff];
               if (req_ff.kind == KIND_INSERT) begin
                  used_ff[slot_ff] <= 1'b1;
                  count_ff         <= count_ff + 7'd1;
                  if (heads_ff[bkt_ff][LinkW-1]) begin
                     heads_ff[bkt_ff] <= {1'b0, slot_ff};
                     state_ff         <= S_OUT;
                  end else begin
                     state_ff <= S_RD;
                  end
               end else begin
                  if (req_ff.kind == KIND_LOOKUP) rsp_ff.status <= ST_NOTFOUND;
                  state_ff <= heads_ff[bkt_ff][LinkW-1] ? S_OUT : S_RD;
                  if (req_ff.kind == KIND_REMOVE && heads_ff[bkt_ff][LinkW-1])
                     rsp_ff.status <= ST_NOTFOUND;
               end
            end
            S_RD: state_ff <= S_CHK;
            S_CHK: begin
               steps_ff <= steps_ff + 7'd1;
               unique case (req_ff.kind)
                  KIND_INSERT: begin
                     cur_ff   <= rd_next_ff;
                     state_ff <= rd_next_ff[LinkW-1] ? S_OUT : S_RD;
                  end
                  KIND_LOOKUP: begin
                     if (rd_key_ff == req_ff.key) begin
                        rsp_ff.status      <= ST_OK;
                        rsp_ff.found_value <= rd_val_ff;
                        state_ff           <= S_OUT;
                     end else begin
                        cur_ff   <= rd_next_ff;
                        state_ff <= (rd_next_ff[LinkW-1] || steps_ff == 7'(PoolEntries - 1))
                                    ? S_OUT : S_RD;
                     end
                  end
                  default: begin
                     if (rd_key_ff == req_ff.key) begin
                        if (prev_ff[LinkW-1]) heads_ff[bkt_ff] <= rd_next_ff;
                        used_ff[cur_ff[IdxW-1:0]] <= 1'b0;
                        if (count_ff != 7'd0) count_ff <= count_ff - 7'd1;
                        rsp_ff.removed_count <= rsp_ff.removed_count + 7'd1;
                     end else begin
                        prev_ff <= cur_ff;
                     end
                     cur_ff <= rd_next_ff;
                     if (rd_next_ff[LinkW-1] || steps_ff == 7'(PoolEntries - 1)) begin
                        state_ff <= S_OUT;
                        if (rsp_ff.removed_count == 7'd0 && rd_key_ff != req_ff.key)
                           rsp_ff.status <= ST_NOTFOUND;
                     end else begin
                        state_ff <= S_RD;
                     end
                  end
               endcase
            end
            S_SWEEP: state_ff <= S_SWCHK;
            S_SWCHK: begin
               if (used_ff[steps_ff[IdxW-1:0]] && (!any_ff || rd_key_ff > rsp_ff.max_key)) begin
                  rsp_ff.max_key <= rd_key_ff;
                  any_ff         <= 1'b1;
               end
               steps_ff <= steps_ff + 7'd1;
               if (steps_ff == 7'(PoolEntries - 1)) begin
                  state_ff <= S_OUT;
                  if (!any_ff && !used_ff[steps_ff[IdxW-1:0]]) rsp_ff.status <= ST_EMPTY;
               end else begin
                  state_ff <= S_SWEEP;
               end
            end
            S_OUT: begin
               rsp_ff.entry_count <= count_ff;
               rsp_valid_ff       <= 1'b1;
               state_ff           <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 7'(PoolEntries)) else $error("entry count overflow");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> req_stall) else $error("ready while busy");
   a_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT) |=> rsp_valid) else $error("result lost");

endmodule

@@ rtl/core/cht_hash.sv @@
module cht_hash
   import cht_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  hash_cmd_type cmd,
   output hash_res_type res
);

   typedef enum logic [2:0] {
      H_IDLE, H_K1, H_K2, H_H1, H_H2, H_MOD, H_DONE
   } hstate_type;

   hstate_type  state_ff;
   logic [31:0] k_ff, h_ff, x_ff;
   logic [4:0]  n_ff;
   logic [31:0] prod;
   logic [31:0] mul_a;

   // largest shift keeping n<<s at or below h
   function automatic logic [4:0] modshift(input logic [31:0] h, input logic [4:0] n);
      logic [4:0]  s;
      logic [36:0] t;
      s = 5'd0;
      for (int i = 1; i < 32; i++) begin
         t = {32'd0, n} << i;
         if (t <= {5'd0, h}) s = 5'(i);
      end
      return s;
   endfunction

   // one shared multiplier by the murmur constant
   always_comb begin
      unique case (state_ff)
         H_K2:    mul_a = k_ff ^ (k_ff >> 24);
         H_H2:    mul_a = x_ff ^ (x_ff >> 13);
         default: mul_a = k_ff;
      endcase
   end
   assign prod = mul_a * MurmurM;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= H_IDLE;
      end else begin
         unique case (state_ff)
            H_IDLE: begin
               if (cmd.start) begin
                  k_ff     <= cmd.key;
                  n_ff     <= (cmd.nbuckets == 5'd0) ? 5'd1 :
                              (cmd.nbuckets > 5'(MaxBuckets)) ? 5'(MaxBuckets) : cmd.nbuckets;
                  state_ff <= H_K1;
               end
            end
            H_K1: begin
               k_ff     <= prod;
               state_ff <= H_K2;
            end
            H_K2: begin
               // h = 4*m, then xor k*m
               x_ff     <= (32'd4 * MurmurM) ^ prod;
               state_ff <= H_H2;
            end
            H_H2: begin
               h_ff     <= prod ^ (prod >> 15);
               state_ff <= H_MOD;
            end
            H_MOD: begin
               // repeated subtraction would be long; reduce via 64-bit-free shift-subtract
               if (h_ff >= {27'd0, n_ff}) begin
                  h_ff <= h_ff - ({27'd0, n_ff} << modshift(h_ff, n_ff));
               end else begin
                  state_ff <= H_DONE;
               end
            end
            H_DONE:  state_ff <= H_IDLE;
            default: state_ff <= H_IDLE;
         endcase
      end
   end

   assign res.done   = (state_ff == H_DONE);
   assign res.bucket = h_ff[BktW-1:0];

endmodule

@@ test/tb.sv @@
module tb;
   import cht_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_word = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_word;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [4:0] csr_data = '0;

   chained_hash_table_engine i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // table model
   logic [4:0]  nb_reg;
   logic [6:0]  heads [MaxBuckets];
   logic [6:0]  links [PoolEntries];
   logic [31:0] keys [PoolEntries];
   logic [31:0] vals [PoolEntries];
   logic        used [PoolEntries];
   logic [6:0]  count;

   req_type pending_words[$];
   rsp_type answers[$];
   int send_idle = 22, recv_idle = 61;
   int errors = 0;
   int hold = 0;
   logic [31:0] key_pool [8];

   function automatic logic [31:0] murmur(input logic [31:0] key);
      logic [31:0] h, k;
      k = key * MurmurM;
      k = k ^ (k >> 24);
      k = k * MurmurM;
      h = 32'd4 * MurmurM;
      h = h ^ k;
      h = h ^ (h >> 13);
      h = h * MurmurM;
      h = h ^ (h >> 15);
      return h;
   endfunction

   function automatic int bucket_of(input logic [31:0] key);
      int n;
      n = int'(nb_reg);
      if (n == 0) n = 1;
      if (n > MaxBuckets) n = MaxBuckets;
      return int'(murmur(key) % n);
   endfunction

   function automatic void table_clear();
      for (int i = 0; i < MaxBuckets; i++) heads[i] = NullLink;
      for (int i = 0; i < PoolEntries; i++) used[i] = 1'b0;
      count = '0;
   endfunction

   function automatic rsp_type table_apply(input req_type w);
      rsp_type r;
      int b, cur, prv, slot, nxt;
      logic any;
      r = '0;
      case (w.kind)
         KIND_INSERT: begin
            slot = -1;
            for (int i = 0; i < PoolEntries; i++)
               if (!used[i] && slot < 0) slot = i;
            if (count >= PoolEntries || slot < 0) begin
               r.status = ST_FULL;
            end else begin
               b = bucket_of(w.key);
               used[slot] = 1'b1;
               keys[slot] = w.key;
               vals[slot] = w.value;
               links[slot] = NullLink;
               cur = int'(heads[b]);
               if (cur >= PoolEntries) begin
                  heads[b] = 7'(slot);
               end else begin
                  for (int s = 0; s < PoolEntries; s++) begin
                     if (links[cur] >= PoolEntries) break;
                     cur = int'(links[cur]);
                  end
                  links[cur] = 7'(slot);
               end
               count++;
            end
         end
         KIND_LOOKUP: begin
            r.status = ST_NOTFOUND;
            cur = int'(heads[bucket_of(w.key)]);
            for (int s = 0; s < PoolEntries && cur < PoolEntries; s++) begin
               if (keys[cur] == w.key) begin
                  r.status = ST_OK;
                  r.found_value = vals[cur];
                  break;
               end
               cur = int'(links[cur]);
            end
         end
         KIND_REMOVE: begin
            b = bucket_of(w.key);
            cur = int'(heads[b]);
            prv = int'(NullLink);
            for (int s = 0; s < PoolEntries && cur < PoolEntries; s++) begin
               nxt = int'(links[cur]);
               if (keys[cur] == w.key) begin
                  if (prv < PoolEntries) links[prv] = 7'(nxt);
                  else heads[b] = 7'(nxt);
                  used[cur] = 1'b0;
                  if (count > 0) count--;
                  r.removed_count++;
               end else begin
                  prv = cur;
               end
               cur = nxt;
            end
            r.status = (r.removed_count > 0) ? ST_OK : ST_NOTFOUND;
         end
         KIND_CLEAR: table_clear();
         KIND_MAXKEY: begin
            any = 1'b0;
            for (int i = 0; i < PoolEntries; i++)
               if (used[i] && (!any || keys[i] > r.max_key)) begin
                  r.max_key = keys[i];
                  any = 1'b1;
               end
            if (!any) r.status = ST_EMPTY;
         end
         default: ;
      endcase
      r.entry_count = count;
      return r;
   endfunction

   // sender
   logic req_take;
   always @(posedge clock) req_take <= req_valid && !req_stall;

   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && !req_take) begin
            // stalled word stays put
         end else if ((hold == 0 || answers.size() == 0) && pending_words.size() > 0 &&
                      $urandom_range(99) >= send_idle) begin
            req_word <= pending_words.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
         rsp_stall <= ($urandom_range(99) < recv_idle);
      end
   end

   // prediction happens at acceptance
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         answers.push_back(table_apply(req_word));
   end

   // result checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (answers.size() == 0) begin
            $display("%0t: unexpected word %p", $time, rsp_word);
            errors++;
         end else begin
            want = answers.pop_front();
            if (rsp_word.status !== want.status) begin
               $display("%0t: status exp %0d got %0d", $time, want.status, rsp_word.status);
               errors++;
            end
            if (rsp_word.found_value !== want.found_value) begin
               $display("%0t: found_value exp %h got %h", $time, want.found_value,
                        rsp_word.found_value);
               errors++;
            end
            if (rsp_word.max_key !== want.max_key) begin
               $display("%0t: max_key exp %h got %h", $time, want.max_key, rsp_word.max_key);
               errors++;
            end
            if (rsp_word.removed_count !== want.removed_count) begin
               $display("%0t: removed_count exp %0d got %0d", $time, want.removed_count,
                        rsp_word.removed_count);
               errors++;
            end
            if (rsp_word.entry_count !== want.entry_count) begin
               $display("%0t: entry_count exp %0d got %0d", $time, want.entry_count,
                        rsp_word.entry_count);
               errors++;
            end
         end
      end
   end

   task automatic push(input kind_type k, input logic [31:0] key, input logic [31:0] v);
      req_type w;
      w.kind = k;
      w.key = key;
      w.value = v;
      pending_words.push_back(w);
   endtask

   task automatic drain();
      while (pending_words.size() > 0 || req_valid || answers.size() > 0)
         @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   task automatic write_buckets(input logic [4:0] n);
      @(negedge clock);
      csr_data <= n;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      nb_reg = n;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic random_items(input int n);
      int sel;
      logic [31:0] key;
      for (int i = 0; i < n; i++) begin
         sel = $urandom_range(99);
         key = ($urandom_range(3) == 0) ? $urandom() : key_pool[$urandom_range(7)];
         if (sel < 45) push(KIND_INSERT, key, $urandom());
         else if (sel < 70) push(KIND_LOOKUP, key, $urandom());
         else if (sel < 88) push(KIND_REMOVE, key, $urandom());
         else if (sel < 92) push(KIND_CLEAR, $urandom(), $urandom());
         else if (sel < 98) push(KIND_MAXKEY, $urandom(), $urandom());
         else push(kind_type'(3'd5 + $urandom_range(2)), $urandom(), $urandom());
      end
   endtask

   initial begin
      logic [4:0] settings [6];
      settings = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd7, 5'd3};
      nb_reg = 5'd10;
      table_clear();
      for (int i = 0; i < 8; i++) key_pool[i] = $urandom();
      key_pool[0] = 32'h0;
      key_pool[1] = 32'hffffffff;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed
      push(KIND_MAXKEY, 0, 0);
      push(KIND_LOOKUP, 32'h0, 0);
      push(KIND_REMOVE, 32'hffffffff, 0);
      push(KIND_INSERT, 32'h0, 32'hffffffff);
      push(KIND_INSERT, 32'hffffffff, 32'h0);
      push(KIND_INSERT, 32'h0, 32'h12345678);
      push(KIND_LOOKUP, 32'h0, 0);
      push(KIND_MAXKEY, 0, 0);
      push(KIND_REMOVE, 32'h0, 0);
      push(KIND_LOOKUP, 32'h0, 0);
      push(kind_type'(3'd7), 32'hffffffff, 32'hffffffff);
      for (int i = 0; i < 66; i++) push(KIND_INSERT, key_pool[i % 8], i);
      push(KIND_REMOVE, key_pool[2], 0);
      push(KIND_CLEAR, 0, 0);
      push(KIND_MAXKEY, 0, 0);
      drain();

      // sender waits for every result before going on
      random_items(40);
      hold = 1;
      drain();
      hold = 0;

      for (int p = 0; p < 6; p++) begin
         write_buckets(settings[p]);
         if (p == 2) begin
            send_idle = 61;
            recv_idle = 22;
         end
         if (p == 4) begin
            send_idle = 0;
            recv_idle = 0;
         end
         random_items(190);
         drain();
      end

      if (errors == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

   initial begin
      #20000000;
      $display("Mismatches found");
      $finish;
   end
endmodule

@@ chained_hash_table_engine.f @@
rtl/core/cht_pkg.sv
rtl/core/cht_hash.sv
rtl/core/chained_hash_table_engine.sv
test/tb.sv
